FILE: rtl/uks_pkg.sv
// Package: request and response beat types, operation and status codes.
package uks_pkg;

	// Operation codes carried in req_type
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// Status codes carried in the response
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_DUP   = 2'd1;
	localparam logic [1:0] STAT_UNDER = 2'd2;
	localparam logic [1:0] STAT_OVER  = 2'd3;

	// Fixed field widths
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned COUNT_W = 7;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [KEY_W-1:0] push_key;
		logic signed [KEY_W-1:0] push_data;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] top_key;
		logic signed [KEY_W-1:0] top_data;
		logic [COUNT_W-1:0]      entry_count;
		logic                    is_empty;
	} rsp_t;

endpackage

FILE: rtl/unique_key_stack.sv
// Top level: bounded LIFO of key/data pairs with duplicate-key refusal on push.
//
//   channel   | handshake          | payload | direction
//   ----------+--------------------+---------+----------
//   request   | start / busy       | req     | in
//   response  | done (one cycle)   | rsp     | out
//
// Push scans the held keys top to bottom through one comparator, one key per
// cycle from the key memory read port, with busy held (no busy when empty).
// Pop and peek hold busy through S_TOP and S_TOPW for the top read; an empty
// stack or an unused code answers without raising busy. The response beat
// shows in the cycle after the last busy cycle, or in the cycle after the
// accept when no busy cycle is needed.
// Reset is asynchronous and empties the stack; memory contents are not cleared.
// The receiver cannot stall; a new request is taken in the cycle done is shown.
module unique_key_stack
	import uks_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	// Sequencer state codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_TOP  = 2'd2;
	localparam logic [1:0] S_TOPW = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     depth_q;
	logic [1:0]        op_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  data_q;
	logic [AW-1:0]     rd_addr_q;
	logic              cmp_v_q;
	logic              cmp_last_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              fin;
	logic [1:0]        fin_status;
	logic [KEY_W-1:0]  fin_key;
	logic [KEY_W-1:0]  fin_data;
	logic              push_ok;
	logic              pop_do;
	logic [1:0]        state_d;
	logic [CW-1:0]     depth_d;
	logic [CW+6:0]     count_ext;
	logic              full;
	logic [CW-1:0]     top_idx;
	logic [KEY_W-1:0]  wr_key;
	logic [KEY_W-1:0]  wr_dat;
	logic [KEY_W-1:0]  rd_key;
	logic [KEY_W-1:0]  rd_dat;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign full    = (depth_q == CW'(DEPTH));
	assign top_idx = depth_q - 1'b1;
	assign wr_key  = (state_q == S_IDLE) ? req.push_key  : key_q;
	assign wr_dat  = (state_q == S_IDLE) ? req.push_data : data_q;

	uks_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH), .AW(AW)) u_key_ram (
		.clk     (clk),
		.wr_en   (push_ok),
		.wr_addr (depth_q[AW-1:0]),
		.wr_data (wr_key),
		.rd_addr (rd_addr_q),
		.rd_data (rd_key)
	);

	uks_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH), .AW(AW)) u_data_ram (
		.clk     (clk),
		.wr_en   (push_ok),
		.wr_addr (depth_q[AW-1:0]),
		.wr_data (wr_dat),
		.rd_addr (rd_addr_q),
		.rd_data (rd_dat)
	);

	// Decide the next step and whether a response finishes this cycle
	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_status = STAT_OK;
		fin_key    = '0;
		fin_data   = '0;
		push_ok    = 1'b0;
		pop_do     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						OP_PUSH: begin
							if (depth_q == '0) begin
								fin     = 1'b1;
								push_ok = 1'b1;
							end else begin
								state_d = S_SCAN;
							end
						end
						OP_POP, OP_PEEK: begin
							if (depth_q == '0) begin
								fin        = 1'b1;
								fin_status = STAT_UNDER;
							end else begin
								state_d = S_TOP;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (cmp_v_q && (rd_key == key_q)) begin
					fin        = 1'b1;
					fin_status = STAT_DUP;
					state_d    = S_IDLE;
				end else if (cmp_v_q && cmp_last_q) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (full) begin
						fin_status = STAT_OVER;
					end else begin
						push_ok = 1'b1;
					end
				end
			end
			S_TOP: begin
				state_d = S_TOPW;
			end
			S_TOPW: begin
				fin      = 1'b1;
				fin_key  = rd_key;
				fin_data = rd_dat;
				pop_do   = (op_q == OP_POP);
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Count after this operation, fitted to the response field
	assign depth_d   = depth_q + CW'(push_ok) - CW'(pop_do);
	assign count_ext = {7'd0, depth_d};

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			depth_q    <= '0;
			done_q     <= 1'b0;
			cmp_v_q    <= 1'b0;
			cmp_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			done_q  <= fin;
			if (accept) begin
				cmp_v_q    <= 1'b0;
				cmp_last_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				cmp_v_q    <= 1'b1;
				cmp_last_q <= (rd_addr_q == '0);
			end
		end
	end

	// Hold the request and step the read address down the stack
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.req_type;
			key_q     <= req.push_key;
			data_q    <= req.push_data;
			rd_addr_q <= top_idx[AW-1:0];
		end else if ((state_q == S_SCAN) && (rd_addr_q != '0)) begin
			rd_addr_q <= rd_addr_q - 1'b1;
		end
	end

	// Register the response beat
	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q.status      <= fin_status;
			rsp_q.top_key     <= fin_key;
			rsp_q.top_data    <= fin_data;
			rsp_q.entry_count <= count_ext[COUNT_W-1:0];
			rsp_q.is_empty    <= (depth_d == '0);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/uks_ram.sv
// Single-port-write, single-port-read memory with registered read data.
module uks_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register the read beat
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/uks_checker.sv
// Port-level checker for the key stack, bound to the top level.
module uks_checker
	import uks_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// Response beat lands only when the sequencer is free
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response beat while busy");

	// An accepted beat either finishes at once or holds busy
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted beat left no trace");

	// Busy rises only after an accepted beat
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// Refused pushes return no pair and leave a nonempty stack
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == STAT_DUP || rsp.status == STAT_OVER)) |->
		(rsp.top_key == '0 && rsp.top_data == '0 && !rsp.is_empty))
		else $error("refused push returned data or empty stack");

	// Underflow reports an empty stack with zero count
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STAT_UNDER) |-> (rsp.is_empty && rsp.entry_count == '0))
		else $error("underflow on a nonempty stack");

endmodule

bind unique_key_stack uks_checker u_uks_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

FILE: tb/sv/tb_unique_key_stack.sv
// Testbench for unique_key_stack: random and directed beats checked against a stack predictor.
module tb_unique_key_stack;
	import uks_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Longest push scans every held key, plus the response cycle
	localparam int unsigned DRAIN_CYCLES = DEPTH + 8;
	localparam int unsigned RANDOM_PER_PHASE = 120;
	localparam longint unsigned RUN_LIMIT = 64'd20_000_000;

	// Stack predictor and store of expected responses
	class uks_scoreboard;
		logic signed [KEY_W-1:0] key_mem [DEPTH];
		logic signed [KEY_W-1:0] data_mem [DEPTH];
		int unsigned held;
		rsp_t expected_rsps [$];
		int unsigned mismatch_count;

		function new();
			held = 0;
			mismatch_count = 0;
		endfunction

		function int unsigned pending();
			return expected_rsps.size();
		endfunction

		function bit holds_key(logic signed [KEY_W-1:0] k);
			for (int i = int'(held) - 1; i >= 0; i--) begin
				if (key_mem[i] == k)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		// Apply one accepted request beat and queue the response it must produce
		function void note_request(req_t r);
			rsp_t want;
			want = '0;
			case (r.req_type)
				OP_PUSH: begin
					// duplicate check wins over the full check
					if (holds_key(r.push_key)) begin
						want.status = STAT_DUP;
					end else if (held >= DEPTH) begin
						want.status = STAT_OVER;
					end else begin
						key_mem[held] = r.push_key;
						data_mem[held] = r.push_data;
						held++;
					end
				end
				OP_POP, OP_PEEK: begin
					if (held == 0) begin
						want.status = STAT_UNDER;
					end else begin
						want.top_key = key_mem[held - 1];
						want.top_data = data_mem[held - 1];
						if (r.req_type == OP_POP)
							held--;
					end
				end
				default: begin
					// unused code leaves the stack alone
				end
			endcase
			want.entry_count = held[COUNT_W-1:0];
			want.is_empty = (held == 0);
			expected_rsps.push_back(want);
		endfunction

		function void report(string what, rsp_t want, rsp_t got);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s: status %0d/%0d key %h/%h data %h/%h count %0d/%0d empty %0b/%0b",
					$time, what, want.status, got.status, want.top_key, got.top_key,
					want.top_data, got.top_data, want.entry_count, got.entry_count,
					want.is_empty, got.is_empty);
		endfunction

		// Compare one response beat with the oldest expectation
		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_rsps.size() == 0) begin
				report("response with none expected (exp/act)", '0, got);
				return;
			end
			want = expected_rsps.pop_front();
			if (got.status !== want.status || got.top_key !== want.top_key ||
					got.top_data !== want.top_data || got.entry_count !== want.entry_count ||
					got.is_empty !== want.is_empty)
				report("response mismatch (exp/act)", want, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	uks_scoreboard sb;
	int unsigned gap_pct;

	unique_key_stack #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#(RUN_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Check every response beat
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_response(rsp);
	end

	function automatic req_t mk_req(input logic [1:0] op, input logic signed [KEY_W-1:0] k,
			input logic signed [KEY_W-1:0] d);
		req_t r;
		r.req_type = op;
		r.push_key = k;
		r.push_data = d;
		return r;
	endfunction

	// Drive one request beat, hold it until taken, then maybe idle a while
	task automatic send_request(input req_t r);
		int unsigned gap_len;
		@(negedge clk);
		start = 1'b1;
		req = r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		if ($urandom_range(99) < gap_pct) begin
			gap_len = ($urandom_range(3) == 0) ? $urandom_range(70, 1) : $urandom_range(4, 1);
			@(negedge clk);
			start = 1'b0;
			req.req_type = 2'($urandom);
			req.push_key = $urandom;
			req.push_data = $urandom;
			repeat (gap_len - 1) @(negedge clk);
		end
	endtask

	// Mix held keys, a small pool around zero, and full-range keys
	function automatic logic signed [KEY_W-1:0] pick_push_key();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 35 && sb.held != 0)
			return sb.key_mem[$urandom_range(sb.held - 1)];
		if (sel < 65)
			return $signed($urandom_range(31)) - 16;
		return $urandom;
	endfunction

	function automatic req_t pick_random_req(input bit grow);
		req_t r;
		int unsigned roll;
		roll = $urandom_range(99);
		r.push_key = pick_push_key();
		r.push_data = $urandom;
		if (roll < 5)
			r.req_type = OP_UNUSED;
		else if (roll < (grow ? 75 : 25))
			r.req_type = OP_PUSH;
		else if (roll < (grow ? 88 : 75))
			r.req_type = OP_POP;
		else
			r.req_type = OP_PEEK;
		return r;
	endfunction

	// Random beats, swinging between growing and shrinking the stack
	task automatic run_random(input int unsigned count);
		bit grow;
		int unsigned left_in_mode;
		grow = 1'b0;
		left_in_mode = 0;
		repeat (count) begin
			if (left_in_mode == 0) begin
				grow = ~grow;
				left_in_mode = $urandom_range(40, 10);
			end
			left_in_mode--;
			send_request(pick_random_req(grow));
		end
	endtask

	initial begin
		logic signed [KEY_W-1:0] fresh;
		int unsigned gap_plan [3];

		gap_plan[0] = 28;
		gap_plan[1] = 82;
		gap_plan[2] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		gap_pct = gap_plan[0];
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty stack, field extremes, duplicates at bottom and top
		send_request(mk_req(OP_PEEK, 32'h1234_5678, 32'h0));
		send_request(mk_req(OP_POP, 32'h0, 32'hFFFF_FFFF));
		send_request(mk_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_request(mk_req(OP_PUSH, 32'h8000_0000, 32'h7FFF_FFFF));
		send_request(mk_req(OP_PUSH, 32'h7FFF_FFFF, 32'h8000_0000));
		send_request(mk_req(OP_PUSH, 32'hFFFF_FFFF, 32'h0000_0000));
		send_request(mk_req(OP_PUSH, 32'h0000_0000, 32'hFFFF_FFFF));
		send_request(mk_req(OP_PUSH, 32'h8000_0000, 32'h1111_1111));
		send_request(mk_req(OP_PUSH, 32'h0000_0000, 32'h2222_2222));
		send_request(mk_req(OP_PEEK, 32'h0, 32'h0));
		send_request(mk_req(OP_UNUSED, 32'h0, 32'h0));
		send_request(mk_req(OP_POP, 32'h0, 32'h0));
		send_request(mk_req(OP_POP, 32'h0, 32'h0));
		send_request(mk_req(OP_PEEK, 32'h0, 32'h0));
		send_request(mk_req(OP_POP, 32'h0, 32'h0));
		send_request(mk_req(OP_POP, 32'h0, 32'h0));
		send_request(mk_req(OP_POP, 32'h0, 32'h0));
		send_request(mk_req(OP_PUSH, 32'h5555_5555, 32'hAAAA_AAAA));
		send_request(mk_req(OP_PUSH, 32'hAAAA_AAAA, 32'h5555_5555));
		send_request(mk_req(OP_POP, 32'h0, 32'h0));
		send_request(mk_req(OP_POP, 32'h0, 32'h0));

		// Fill to the top with fresh keys
		while (sb.held < DEPTH) begin
			fresh = $urandom;
			if (!sb.holds_key(fresh))
				send_request(mk_req(OP_PUSH, fresh, $urandom));
		end
		// On a full stack a held key answers duplicate, a fresh one overflow
		send_request(mk_req(OP_PUSH, sb.key_mem[0], $urandom));
		send_request(mk_req(OP_PUSH, sb.key_mem[DEPTH-1], $urandom));
		repeat (2) begin
			do fresh = $urandom; while (sb.holds_key(fresh));
			send_request(mk_req(OP_PUSH, fresh, $urandom));
		end
		send_request(mk_req(OP_PEEK, $urandom, $urandom));
		// Drain to empty, then one pop past the bottom
		while (sb.held != 0)
			send_request(mk_req(OP_POP, $urandom, $urandom));
		send_request(mk_req(OP_POP, $urandom, $urandom));

		// Random phases; drop start and wait for every response between them
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = gap_plan[ph];
			run_random(RANDOM_PER_PHASE);
			@(negedge clk);
			start = 1'b0;
			while (sb.pending() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
